### hw/rtl/jss_pkg.sv
// ----------------------------------------------------------------------------
// jss_pkg
// Shared types and constants for the JTAG scan sequencer.
// ----------------------------------------------------------------------------
package jss_pkg;

    localparam int DATA_W = 32;  // width of shift, TDO and capture words
    localparam int LEN_W  = 6;   // width of the scan length field
    localparam int OP_W   = 2;
    localparam int PRE_W  = 3;   // preamble / reset pulse counter

    localparam logic [OP_W-1:0] OP_TAP_RESET = 2'd0;
    localparam logic [OP_W-1:0] OP_IR_SCAN   = 2'd1;
    localparam logic [OP_W-1:0] OP_DR_SCAN   = 2'd2;

    // reset: pulses 0..4 TMS high, pulse 5 TMS low
    localparam logic [PRE_W-1:0] RESET_LAST = 3'd5;
    // IR preamble indices 0..3 (TMS 1,1,0,0); DR starts at index 1 (1,0,0)
    localparam logic [PRE_W-1:0] PRE_IR_FIRST = 3'd0;
    localparam logic [PRE_W-1:0] PRE_DR_FIRST = 3'd1;
    localparam logic [PRE_W-1:0] PRE_LAST     = 3'd3;

    // controller to datapath
    typedef struct packed {
        logic load;     // command word accepted this cycle
        logic load_dr;  // accepted word is a data scan
        logic pulse;    // a TCK pulse is issued this cycle
        logic shift;    // the pulse is a shift pulse
        logic tms;      // TMS level of the pulse
        logic last;     // final pulse of the command
    } jss_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic last_bit; // the next shift pulse is the final one
    } jss_stat_t;

endpackage

### hw/rtl/jss_ctrl.sv
// ----------------------------------------------------------------------------
// jss_ctrl
// Pulse sequencer: walks the TAP through reset, preamble, shift, update, idle.
// ----------------------------------------------------------------------------
module jss_ctrl (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [jss_pkg::OP_W-1:0] op,
    input  jss_pkg::jss_stat_t       stat,
    output jss_pkg::jss_cmd_t        cmd,
    output logic                     busy
);
    import jss_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RESET,
        ST_PRE,
        ST_SHIFT,
        ST_UPDATE,
        ST_RUN_IDLE
    } state_t;

    state_t           state_reg, state_next;
    logic [PRE_W-1:0] cnt_reg, cnt_next;

    logic accept;

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && (state_reg == ST_IDLE);

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        cmd.load    = 1'b0;
        cmd.load_dr = 1'b0;
        cmd.pulse   = 1'b0;
        cmd.shift   = 1'b0;
        cmd.tms     = 1'b0;
        cmd.last    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_TAP_RESET:
                        begin
                            cmd.load   = 1'b1;
                            cnt_next   = '0;
                            state_next = ST_RESET;
                        end
                        OP_IR_SCAN:
                        begin
                            cmd.load   = 1'b1;
                            cnt_next   = PRE_IR_FIRST;
                            state_next = ST_PRE;
                        end
                        OP_DR_SCAN:
                        begin
                            cmd.load    = 1'b1;
                            cmd.load_dr = 1'b1;
                            cnt_next    = PRE_DR_FIRST;
                            state_next  = ST_PRE;
                        end
                        default: ;  // unused opcode, dropped
                    endcase
                end
            end
            ST_RESET:
            begin
                cmd.pulse = 1'b1;
                cmd.tms   = (cnt_reg != RESET_LAST);
                cmd.last  = (cnt_reg == RESET_LAST);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == RESET_LAST)
                    state_next = ST_IDLE;
            end
            ST_PRE:
            begin
                cmd.pulse = 1'b1;
                cmd.tms   = (cnt_reg < 3'd2);
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg == PRE_LAST)
                    state_next = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                cmd.pulse = 1'b1;
                cmd.shift = 1'b1;
                cmd.tms   = stat.last_bit;
                if (stat.last_bit)
                    state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.pulse  = 1'b1;
                cmd.tms    = 1'b1;
                state_next = ST_RUN_IDLE;
            end
            ST_RUN_IDLE:
            begin
                cmd.pulse  = 1'b1;
                cmd.last   = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    a_shift_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SHIFT && !stat.last_bit) |=> (state_reg == ST_SHIFT))
        else $error("shift state left before the final bit");

    a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_RESET || state_reg == ST_PRE))
        else $error("accepted word did not start a sequence");

    a_idle_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RUN_IDLE) |=> (state_reg == ST_IDLE))
        else $error("run-idle pulse not followed by idle");

endmodule

### hw/rtl/jss_datapath.sv
// ----------------------------------------------------------------------------
// jss_datapath
// Shift register, bit counter, TDI hold and registered result ports.
// ----------------------------------------------------------------------------
module jss_datapath #(
    parameter int MAX_SCAN_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  jss_pkg::jss_cmd_t          cmd,
    output jss_pkg::jss_stat_t         stat,
    input  logic [jss_pkg::DATA_W-1:0] shift_data,
    input  logic [jss_pkg::LEN_W-1:0]  scan_length,
    input  logic [jss_pkg::DATA_W-1:0] tdo_levels,
    output logic                       strobe,
    output logic                       tms_level,
    output logic                       tdi_level,
    output logic [jss_pkg::DATA_W-1:0] captured,
    output logic                       last_pulse
);
    import jss_pkg::*;

    localparam int CNT_W = (MAX_SCAN_BITS > 1) ? $clog2(MAX_SCAN_BITS) : 1;
    localparam int SAT_W = LEN_W + 1;
    localparam logic [SAT_W-1:0] MAX_LEN  = SAT_W'(MAX_SCAN_BITS);
    localparam logic [SAT_W-1:0] WORD_LEN = SAT_W'(DATA_W);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] cap_reg;
    logic [CNT_W-1:0]  bit_cnt_reg;
    logic              hold_reg;

    logic              strobe_reg, tms_reg, tdi_reg, last_reg;
    logic [DATA_W-1:0] captured_reg;

    logic [SAT_W-1:0]  len_sat;
    logic [DATA_W-1:0] cap_mask;

    // length clamped to 1..MAX_SCAN_BITS
    always_comb
    begin
        len_sat = {1'b0, scan_length};
        if (len_sat == '0)
            len_sat = SAT_W'(1);
        if (len_sat > MAX_LEN)
            len_sat = MAX_LEN;
        if (len_sat >= WORD_LEN)
            cap_mask = '1;
        else
            cap_mask = (DATA_W'(1) << len_sat) - DATA_W'(1);
    end

    assign stat.last_bit = (bit_cnt_reg == '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_reg     <= 1'b0;
            strobe_reg   <= 1'b0;
            tms_reg      <= 1'b0;
            tdi_reg      <= 1'b0;
            last_reg     <= 1'b0;
            captured_reg <= '0;
            data_reg     <= '0;
            cap_reg      <= '0;
            bit_cnt_reg  <= '0;
        end
        else
        begin
            strobe_reg   <= cmd.pulse;
            tms_reg      <= cmd.tms;
            last_reg     <= cmd.last;
            tdi_reg      <= cmd.shift ? data_reg[0] : hold_reg;
            captured_reg <= cmd.last ? cap_reg : '0;
            if (cmd.load)
            begin
                data_reg    <= shift_data;
                cap_reg     <= cmd.load_dr ? (tdo_levels & cap_mask) : '0;
                bit_cnt_reg <= CNT_W'(len_sat - SAT_W'(1));
            end
            else if (cmd.shift)
            begin
                hold_reg    <= data_reg[0];
                data_reg    <= {1'b0, data_reg[DATA_W-1:1]};  // zero beyond bit 31
                bit_cnt_reg <= bit_cnt_reg - 1'b1;
            end
        end
    end

    assign strobe     = strobe_reg;
    assign tms_level  = tms_reg;
    assign tdi_level  = tdi_reg;
    assign captured   = captured_reg;
    assign last_pulse = last_reg;

    a_cap_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        !last_reg |-> (captured_reg == '0))
        else $error("capture word outside the final pulse");

    a_shift_tdi: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.shift |=> (tdi_reg == hold_reg))
        else $error("TDI hold not tracking the shifted bit");

    a_strobe_marks: assert property (@(posedge clk) disable iff (!rst_n)
        last_reg |-> strobe_reg)
        else $error("final pulse flag without a strobe");

endmodule

### hw/rtl/jtag_scan_sequencer.sv
// ----------------------------------------------------------------------------
// jtag_scan_sequencer
// JTAG TAP master: turns one command word into a train of TCK pulse words.
// ----------------------------------------------------------------------------
// A command word is taken when start is high and busy is low. It is then
// played out as one result word per clock, each marked by strobe for a single
// cycle; the receiver must take every word as it comes. A TAP reset gives 6
// words, an instruction scan L+6 and a data scan L+5, where L is scan_length
// clamped to 1..MAX_SCAN_BITS. The first word is registered from the pulse
// state entered at the accepting edge, and busy drops in the cycle the last
// word is on the ports, so a new command can be accepted while that last word
// is on the ports: the controller issues one pulse per clock.
// Opcode 3 is accepted and produces nothing.
//
// Notes:
//  - TDI outside the shift phase repeats the last level shifted out; it is
//    zero after reset.
//  - captured is non-zero only on the final word of a data scan and holds
//    the TDO bits for the shifted positions only.
//  - shift bits above bit 31 drive TDI low.
// ----------------------------------------------------------------------------
module jtag_scan_sequencer #(
    parameter int MAX_SCAN_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [jss_pkg::OP_W-1:0]   op,
    input  logic [jss_pkg::DATA_W-1:0] shift_data,
    input  logic [jss_pkg::LEN_W-1:0]  scan_length,
    input  logic [jss_pkg::DATA_W-1:0] tdo_levels,
    output logic                       strobe,
    output logic                       tms_level,
    output logic                       tdi_level,
    output logic [jss_pkg::DATA_W-1:0] captured,
    output logic                       last_pulse
);
    import jss_pkg::*;

    jss_cmd_t  cmd;
    jss_stat_t stat;

    // pulse sequencer
    jss_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .op    (op),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy)
    );

    // shift register, counter and result registers
    jss_datapath #(
        .MAX_SCAN_BITS (MAX_SCAN_BITS)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .shift_data  (shift_data),
        .scan_length (scan_length),
        .tdo_levels  (tdo_levels),
        .strobe      (strobe),
        .tms_level   (tms_level),
        .tdi_level   (tdi_level),
        .captured    (captured),
        .last_pulse  (last_pulse)
    );

endmodule
